// ----- hdl/urlpd_pkg.sv -----
package urlpd_pkg;

  // Special characters
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DEL     = 8'd127;
  localparam logic [7:0] CTRL_LIMIT = 8'd32;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_INVALID    = 2'd2,
    ST_CONTROL    = 2'd3
  } status_t;

  // Escape phase, one-hot
  typedef enum logic [2:0] {
    PH_TEXT = 3'b001,
    PH_HI   = 3'b010,
    PH_LO   = 3'b100
  } phase_t;

  // Registered input request
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } in_req_t;

  // Decoder result for one request
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    status_t    status;
    logic       eos;
  } res_t;

  function automatic logic hex_ok(input logic [7:0] c);
    hex_ok = (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
             (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= "0" && c <= "9") begin
      v = c - 8'h30;
    end else if (c >= "a" && c <= "f") begin
      v = c - 8'h57;
    end else if (c >= "A" && c <= "F") begin
      v = c - 8'h37;
    end else begin
      v = 8'd0;
    end
    hex_val = v[3:0];
  endfunction

  function automatic logic is_ctrl(input logic [7:0] c);
    is_ctrl = (c < CTRL_LIMIT) || (c == CH_DEL);
  endfunction

endpackage

// ----- hdl/urlpd_in_reg.sv -----
module urlpd_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_is_last,
  input  logic              take,
  output urlpd_pkg::in_req_t req
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       load;

  // Free when empty or when the held request moves on this cycle
  assign in_ready = !valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_byte;
      last_r <= in_is_last;
    end
  end

  assign req.valid = valid_r;
  assign req.data  = data_r;
  assign req.last  = last_r;

endmodule

// ----- hdl/urlpd_decode.sv -----
module urlpd_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  urlpd_pkg::in_req_t req,
  input  logic              take,
  output urlpd_pkg::res_t   res
);

  urlpd_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]        nib_r, nib_nxt;
  logic              disc_r, disc_nxt;

  logic [7:0]        c;
  logic              last;
  logic              hok;
  logic [3:0]        hv;
  logic [7:0]        byte_v;
  logic              byte_go;

  assign c    = req.data;
  assign last = req.last;
  assign hok  = urlpd_pkg::hex_ok(c);
  assign hv   = urlpd_pkg::hex_val(c);

  // Next state and result for the held request
  always_comb begin
    phase_nxt  = phase_r;
    nib_nxt    = nib_r;
    disc_nxt   = disc_r;
    res.emit   = 1'b0;
    res.data   = 8'd0;
    res.status = urlpd_pkg::ST_OK;
    res.eos    = 1'b0;
    byte_v     = 8'd0;
    byte_go    = 1'b0;

    if (disc_r) begin
      // dropping rest of a failed string
      if (last) begin
        disc_nxt  = 1'b0;
        phase_nxt = urlpd_pkg::PH_TEXT;
        nib_nxt   = 4'd0;
      end
    end else begin
      unique case (phase_r)
        urlpd_pkg::PH_HI: begin
          if (last) begin
            res.emit   = 1'b1;
            res.status = urlpd_pkg::ST_INCOMPLETE;
            res.eos    = 1'b1;
            phase_nxt  = urlpd_pkg::PH_TEXT;
            nib_nxt    = 4'd0;
          end else if (!hok) begin
            res.emit   = 1'b1;
            res.status = urlpd_pkg::ST_INVALID;
            res.eos    = 1'b1;
            phase_nxt  = urlpd_pkg::PH_TEXT;
            nib_nxt    = 4'd0;
            disc_nxt   = 1'b1;
          end else begin
            nib_nxt   = hv;
            phase_nxt = urlpd_pkg::PH_LO;
          end
        end
        urlpd_pkg::PH_LO: begin
          if (!hok) begin
            res.emit   = 1'b1;
            res.status = urlpd_pkg::ST_INVALID;
            res.eos    = 1'b1;
            phase_nxt  = urlpd_pkg::PH_TEXT;
            nib_nxt    = 4'd0;
            disc_nxt   = !last;
          end else begin
            phase_nxt = urlpd_pkg::PH_TEXT;
            byte_v    = {nib_r, hv};
            byte_go   = 1'b1;
          end
        end
        default: begin
          phase_nxt = urlpd_pkg::PH_TEXT;
          if (c == urlpd_pkg::CH_PERCENT) begin
            if (last) begin
              res.emit   = 1'b1;
              res.status = urlpd_pkg::ST_INCOMPLETE;
              res.eos    = 1'b1;
              nib_nxt    = 4'd0;
            end else begin
              phase_nxt = urlpd_pkg::PH_HI;
            end
          end else begin
            byte_v  = (c == urlpd_pkg::CH_PLUS) ? urlpd_pkg::CH_SPACE : c;
            byte_go = 1'b1;
          end
        end
      endcase

      // decoded or plain byte: control check
      if (byte_go) begin
        res.emit = 1'b1;
        if (urlpd_pkg::is_ctrl(byte_v)) begin
          res.status = urlpd_pkg::ST_CONTROL;
          res.eos    = 1'b1;
          phase_nxt  = urlpd_pkg::PH_TEXT;
          nib_nxt    = 4'd0;
          disc_nxt   = !last;
        end else begin
          res.data = byte_v;
          res.eos  = last;
          if (last) begin
            nib_nxt = 4'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= urlpd_pkg::PH_TEXT;
      nib_r   <= 4'd0;
      disc_r  <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      nib_r   <= nib_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule

// ----- hdl/urlpd_out_reg.sv -----
module urlpd_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  urlpd_pkg::res_t res,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_status,
  output logic            out_end_of_string
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic [1:0] status_r;
  logic       eos_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r   <= res.data;
      status_r <= res.status;
      eos_r    <= res.eos;
    end
  end

  assign out_valid         = valid_r;
  assign out_byte          = data_r;
  assign out_status        = status_r;
  assign out_end_of_string = eos_r;

endmodule

// ----- hdl/url_percent_decoder_top.sv -----
// URL query-string percent decoder.
// Input channel: in_valid/in_ready with in_byte and in_is_last, one raw byte
// per request; in_is_last marks the end of a string.
// Result channel: out_valid/out_ready with out_byte, out_status
// (0 ok, 1 incomplete escape, 2 bad hex digit, 3 control character) and
// out_end_of_string. A request gives zero or one result: '%' and a good first
// hex digit give none unless last, nor do bytes dropped after an error.
// Throughput: one byte per cycle unless a result waits on out_ready, set by
// the single decode stage between the input register and the result register.
// A byte accepted into the input register is decoded from it combinationally
// and its result is loaded into the result register, which drives out_valid,
// when not stalled.
// Reset (synchronous, rst_n low) empties both registers and returns the
// decoder to plain text. When out_ready is low the result register holds;
// a byte that gives no result still moves on, and one that gives a result
// waits in the input register, so in_ready falls only when both are full.
module url_percent_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_status,
  output logic       out_end_of_string
);

  urlpd_pkg::in_req_t req;
  urlpd_pkg::res_t    res;
  logic               take;
  logic               out_space;

  // Held request moves on when its result (if any) has room
  assign out_space = !out_valid || out_ready;
  assign take      = req.valid && (!res.emit || out_space);

  urlpd_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_is_last (in_is_last),
    .take       (take),
    .req        (req)
  );

  urlpd_decode u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .take  (take),
    .res   (res)
  );

  urlpd_out_reg u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (take && res.emit),
    .res               (res),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_byte          (out_byte),
    .out_status        (out_status),
    .out_end_of_string (out_end_of_string)
  );

`ifndef SYNTHESIS
  // Error results always close the string and carry a zero byte
  a_err_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != urlpd_pkg::ST_OK) |->
      (out_end_of_string && out_byte == 8'd0))
    else $error("error result without end of string or with nonzero byte");

  // A request that produces a result shows up in the result register
  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res.emit) |=> out_valid)
    else $error("result lost between decode and result register");

  // Back-pressure on the input only when a request is held
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (req.valid && res.emit && out_valid && !out_ready))
    else $error("input stalled without cause");
`endif

endmodule
